// File: sv/tsli_pkg.sv
// Shared types, constants and codes for the timestamp search block.
`default_nettype none
package tsli_pkg;
    localparam int STORE_DEPTH_DEF = 256;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int STAMP_W = 64;
    localparam int FRAC_W = 16;

    localparam logic [1:0] MODE_APPEND = 2'd0;
    localparam logic [1:0] MODE_QUERY  = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    localparam logic [2:0] ST_INTERP = 3'd0;
    localparam logic [2:0] ST_FOUND  = 3'd1;
    localparam logic [2:0] ST_PAST   = 3'd2;
    localparam logic [2:0] ST_EMPTY  = 3'd3;
    localparam logic [2:0] ST_DROP   = 3'd4;

    typedef struct packed {
        logic [1:0]         mode;
        logic [63:0]        stamp;
        logic signed [31:0] accel_x;
        logic signed [31:0] accel_y;
        logic signed [31:0] accel_z;
        logic signed [31:0] rate_x;
        logic signed [31:0] rate_y;
        logic signed [31:0] rate_z;
    } tsli_in_t;

    typedef struct packed {
        logic [63:0]        out_stamp;
        logic signed [31:0] out_accel_x;
        logic signed [31:0] out_accel_y;
        logic signed [31:0] out_accel_z;
        logic signed [31:0] out_rate_x;
        logic signed [31:0] out_rate_y;
        logic signed [31:0] out_rate_z;
        logic [2:0]         status;
    } tsli_out_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic load_in;      // capture input item
        logic write_rd;     // store the captured reading at fill
        logic fill_inc;
        logic fill_clr;
        logic srch_init;
        logic rd_mid;       // read store at mid
        logic srch_step;    // update lo/hi from read data
        logic rd_lo;        // read store at lo
        logic rd_prev;      // read store at lo-1
        logic cap_next;     // latch next reading
        logic cap_prev;     // latch prev reading, start divide
        logic div_step;
        logic mul_step;     // multiply one axis
        logic [1:0] axis;
        logic emit_zero;
        logic emit_rd;      // emit latched next reading
        logic emit_interp;
        logic [2:0] status;
    } tsli_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic [1:0] mode;
        logic empty;
        logic full;
        logic out_of_order;
        logic srch_done;
        logic past_end;
        logic exact_or_first;
    } tsli_sts_t;
endpackage
`default_nettype wire

// File: sv/tsli_dp.sv
// Datapath: reading store, search registers, serial divider, interpolation.
`default_nettype none
module tsli_dp
    import tsli_pkg::*;
#(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire tsli_in_t  in_item,
    input  wire tsli_cmd_t cmd,
    output tsli_sts_t      sts,
    output tsli_out_t      out_item
);
    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CW = $clog2(STORE_DEPTH + 1);
    localparam int VW = VALUE_WIDTH;
    localparam int RW = STAMP_W + 6 * VW;

    logic [RW-1:0] mem [STORE_DEPTH];
    logic [RW-1:0] rd_data_reg;

    tsli_in_t in_reg;
    logic [CW-1:0] fill_reg;
    logic [STAMP_W-1:0] last_stamp_reg;
    logic [CW-1:0] lo_reg, hi_reg;
    logic [RW-1:0] next_reg, prev_reg;
    logic [STAMP_W:0] rem_reg;
    logic [STAMP_W-1:0] den_reg;
    logic [FRAC_W-1:0] q_reg;
    logic signed [VW-1:0] res_reg [3];
    tsli_out_t out_reg;

    logic [CW-1:0] mid;
    logic [CW-1:0] addr;
    logic [RW-1:0] wr_word;
    logic [STAMP_W-1:0] rd_stamp;

    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign rd_stamp = rd_data_reg[RW-1 -: STAMP_W];
    assign wr_word = {in_reg.stamp, in_reg.accel_x[VW-1:0], in_reg.accel_y[VW-1:0],
                      in_reg.accel_z[VW-1:0], in_reg.rate_x[VW-1:0],
                      in_reg.rate_y[VW-1:0], in_reg.rate_z[VW-1:0]};

    always_comb begin
        addr = fill_reg;
        if (cmd.rd_mid) addr = mid;
        else if (cmd.rd_lo) addr = lo_reg;
        else if (cmd.rd_prev) addr = lo_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (cmd.write_rd) mem[addr[AW-1:0]] <= wr_word;
        rd_data_reg <= mem[addr[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else if (cmd.fill_clr) begin
            fill_reg <= '0;
        end else if (cmd.fill_inc) begin
            fill_reg <= fill_reg + 1'b1;
        end
    end

    // Restoring divide step and interpolation working registers.
    logic [STAMP_W:0] rem_sh;
    logic signed [VW:0] diff;
    logic signed [VW+FRAC_W+1:0] prod;
    logic signed [VW+1:0] sum;
    logic [1:0] ax;

    assign ax = cmd.axis;
    always_comb begin
        rem_sh = {rem_reg[STAMP_W-1:0], 1'b0};
        diff = $signed({next_reg[RW-STAMP_W-1-VW*ax -: 1], next_reg[RW-STAMP_W-1-VW*ax -: VW]})
             - $signed({prev_reg[RW-STAMP_W-1-VW*ax -: 1], prev_reg[RW-STAMP_W-1-VW*ax -: VW]});
        prod = diff * $signed({1'b0, q_reg});
        // arithmetic shift floors toward minus infinity
        sum = (VW+2)'($signed({{2{prev_reg[RW-STAMP_W-1-VW*ax]}},
                               prev_reg[RW-STAMP_W-1-VW*ax -: VW]}) + (prod >>> FRAC_W));
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) in_reg <= in_item;
        if (cmd.write_rd) last_stamp_reg <= in_reg.stamp;
        if (cmd.srch_init) begin
            lo_reg <= '0;
            hi_reg <= fill_reg;
        end else if (cmd.srch_step) begin
            if (rd_stamp < in_reg.stamp) lo_reg <= mid + 1'b1;
            else hi_reg <= mid;
        end
        if (cmd.cap_next) next_reg <= rd_data_reg;
        if (cmd.cap_prev) begin
            prev_reg <= rd_data_reg;
            rem_reg <= {1'b0, in_reg.stamp - rd_stamp};
            den_reg <= next_reg[RW-1 -: STAMP_W] - rd_stamp;
            q_reg <= '0;
        end else if (cmd.div_step) begin
            if (rem_sh >= {1'b0, den_reg}) begin
                rem_reg <= rem_sh - {1'b0, den_reg};
                q_reg <= {q_reg[FRAC_W-2:0], 1'b1};
            end else begin
                rem_reg <= rem_sh;
                q_reg <= {q_reg[FRAC_W-2:0], 1'b0};
            end
        end
        if (cmd.mul_step) res_reg[ax] <= sum[VW-1:0];
        if (cmd.emit_zero) begin
            out_reg <= '0;
            out_reg.status <= cmd.status;
        end else if (cmd.emit_rd) begin
            out_reg.out_stamp <= next_reg[RW-1 -: STAMP_W];
            out_reg.out_accel_x <= 32'(signed'(next_reg[6*VW-1 -: VW]));
            out_reg.out_accel_y <= 32'(signed'(next_reg[5*VW-1 -: VW]));
            out_reg.out_accel_z <= 32'(signed'(next_reg[4*VW-1 -: VW]));
            out_reg.out_rate_x <= 32'(signed'(next_reg[3*VW-1 -: VW]));
            out_reg.out_rate_y <= 32'(signed'(next_reg[2*VW-1 -: VW]));
            out_reg.out_rate_z <= 32'(signed'(next_reg[VW-1 -: VW]));
            out_reg.status <= cmd.status;
        end else if (cmd.emit_interp) begin
            out_reg.out_stamp <= in_reg.stamp;
            out_reg.out_accel_x <= 32'(res_reg[0]);
            out_reg.out_accel_y <= 32'(res_reg[1]);
            out_reg.out_accel_z <= 32'(res_reg[2]);
            out_reg.out_rate_x <= '0;
            out_reg.out_rate_y <= '0;
            out_reg.out_rate_z <= '0;
            out_reg.status <= ST_INTERP;
        end
    end

    assign out_item = out_reg;
    assign sts.mode = in_reg.mode;
    assign sts.empty = (fill_reg == '0);
    assign sts.full = (fill_reg >= CW'(STORE_DEPTH));
    assign sts.out_of_order = (fill_reg != '0) && (in_reg.stamp < last_stamp_reg);
    assign sts.srch_done = (lo_reg >= hi_reg);
    assign sts.past_end = (lo_reg >= fill_reg);
    // compare against the latched reading; the store read port has moved on
    assign sts.exact_or_first = (lo_reg == '0) ||
                                (next_reg[RW-1 -: STAMP_W] == in_reg.stamp);
endmodule
`default_nettype wire

// File: sv/tsli_ctrl.sv
// Controller: sequences append, clear and query through the datapath.
`default_nettype none
module tsli_ctrl
    import tsli_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  wire logic      m_ready,
    input  wire tsli_sts_t sts,
    output tsli_cmd_t      cmd
);
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_SRCH   = 4'd2;
    localparam logic [3:0] S_SWAIT  = 4'd3;
    localparam logic [3:0] S_LO     = 4'd4;
    localparam logic [3:0] S_LOWAIT = 4'd5;
    localparam logic [3:0] S_PREV   = 4'd6;
    localparam logic [3:0] S_PWAIT  = 4'd7;
    localparam logic [3:0] S_DIV    = 4'd8;
    localparam logic [3:0] S_MUL    = 4'd9;
    localparam logic [3:0] S_OUT    = 4'd10;
    localparam logic [3:0] S_LOCHK  = 4'd11;

    logic [3:0] state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == S_IDLE) && !m_valid_reg;
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    cmd.load_in = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                state_next = S_IDLE;
                case (sts.mode)
                    MODE_APPEND: begin
                        if (sts.full || sts.out_of_order) begin
                            cmd.emit_zero = 1'b1;
                            cmd.status = ST_DROP;
                            m_valid_next = 1'b1;
                        end else begin
                            cmd.write_rd = 1'b1;
                            cmd.fill_inc = 1'b1;
                        end
                    end
                    MODE_QUERY: begin
                        if (sts.empty) begin
                            cmd.emit_zero = 1'b1;
                            cmd.status = ST_EMPTY;
                            m_valid_next = 1'b1;
                        end else begin
                            cmd.srch_init = 1'b1;
                            state_next = S_SRCH;
                        end
                    end
                    MODE_CLEAR: cmd.fill_clr = 1'b1;
                    default: ;
                endcase
            end
            S_SRCH: begin
                if (sts.srch_done) begin
                    state_next = S_LO;
                end else begin
                    cmd.rd_mid = 1'b1;
                    state_next = S_SWAIT;
                end
            end
            S_SWAIT: begin
                cmd.srch_step = 1'b1;
                state_next = S_SRCH;
            end
            S_LO: begin
                // past end reads the last reading instead
                if (sts.past_end) cmd.rd_prev = 1'b1;
                else cmd.rd_lo = 1'b1;
                state_next = S_LOWAIT;
            end
            S_LOWAIT: begin
                cmd.cap_next = 1'b1;
                state_next = S_LOCHK;
            end
            S_LOCHK: begin
                if (sts.past_end || sts.exact_or_first) begin
                    cmd.emit_rd = 1'b1;
                    cmd.status = sts.past_end ? ST_PAST : ST_FOUND;
                    m_valid_next = 1'b1;
                    state_next = S_IDLE;
                end else begin
                    cmd.rd_prev = 1'b1;
                    state_next = S_PWAIT;
                end
            end
            S_PWAIT: begin
                cmd.cap_prev = 1'b1;
                cnt_next = '0;
                state_next = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 5'(FRAC_W - 1)) begin
                    cnt_next = '0;
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                cmd.mul_step = 1'b1;
                cmd.axis = cnt_reg[1:0];
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 5'd2) state_next = S_OUT;
            end
            S_OUT: begin
                cmd.emit_interp = 1'b1;
                m_valid_next = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !s_ready) else $error("accept while busy");
    a_emit_from_idle_path: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> (state_reg == S_IDLE)) else $error("result mid query");
    a_div_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |-> (cnt_reg < 5'(FRAC_W))) else $error("divide overrun");
endmodule
`default_nettype wire

// File: sv/timestamp_search_linear_interp.sv
// Top level of the timestamp search and interpolation block.
//   channel | dir | handshake        | payload
//   s_      | in  | s_valid/s_ready  | s_data (tsli_in_t)
//   m_      | out | m_valid/m_ready  | m_data (tsli_out_t)
// Append, clear: no result; dropped append or empty query: a zero result with its status.
// Query: k binary search steps (at most 9 at depth 256), a read at lo, then found or past end;
// interpolation adds a read at lo-1, 16 divide steps, 3 multiply steps (accel axes) and the emit;
// the store is single-port with a registered read, and the divider is bit-serial.
// Reset clears the fill count and the controller state; the store needs no clearing pass.
// A pending result blocks the next transfer until m_ready takes it.
`default_nettype none
module timestamp_search_linear_interp
    import tsli_pkg::*;
#(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire tsli_in_t s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output tsli_out_t     m_data
);
    tsli_cmd_t cmd;
    tsli_sts_t sts;

    tsli_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .sts(sts), .cmd(cmd)
    );

    tsli_dp #(.STORE_DEPTH(STORE_DEPTH), .VALUE_WIDTH(VALUE_WIDTH)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .in_item(s_data), .cmd(cmd),
        .sts(sts), .out_item(m_data)
    );
endmodule
`default_nettype wire
